>>> design/ppu_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Perspective projection unit package
// Shared widths, codes, configuration and job types of the projection unit.
// ----------------------------------------------------------------------------
package ppu_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int WORD_BITS_DEF = 32;

    localparam int DATA_W    = 32;
    localparam int RATIO_W   = 31;
    localparam int CFG_IDX_W = 3;

    // Signed width of a product operand and its magnitude.
    localparam int A_W  = 62;
    localparam int MA_W = 61;
    // Signed width of a multiplier operand and its magnitude.
    localparam int B_W  = 56;
    localparam int MB_W = 55;

    localparam int FIFO_DEPTH = 4;

    localparam logic [MA_W-1:0] BIG_MAG = {1'b1, {(MA_W-1){1'b0}}};

    typedef enum logic {
        CMD_FWD = 1'b0,
        CMD_INV = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_ZERO = 2'd1,
        ST_SAT  = 2'd2
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_INV_FOV      = 3'd0,
        REG_FOV          = 3'd1,
        REG_ASPECT       = 3'd2,
        REG_INV_ASPECT   = 3'd3,
        REG_CENTER_X     = 3'd4,
        REG_CENTER_Y     = 3'd5,
        REG_DEVICE_SPACE = 3'd6
    } t_reg;

    typedef struct packed {
        logic [RATIO_W-1:0]       inv_fov;
        logic [RATIO_W-1:0]       fov;
        logic [RATIO_W-1:0]       aspect;
        logic [RATIO_W-1:0]       inv_aspect;
        logic signed [DATA_W-1:0] center_x;
        logic signed [DATA_W-1:0] center_y;
        logic                     device_space;
    } t_cfg;

    typedef struct packed {
        t_cmd                     cmd;
        logic                     zero;
        logic signed [DATA_W-1:0] z;
        logic [DATA_W-1:0]        zmag;
        logic signed [B_W-1:0]    iz;
        logic signed [A_W-1:0]    ax;
        logic signed [A_W-1:0]    ay;
    } t_job;

    typedef struct packed {
        logic signed [DATA_W-1:0] out_x;
        logic signed [DATA_W-1:0] out_y;
        logic signed [DATA_W-1:0] out_z;
        logic [1:0]               status;
    } t_result;

endpackage
`default_nettype wire

>>> design/ppu_req_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Request channel
// Carries one projection request word: command and three operands.
// ----------------------------------------------------------------------------
interface ppu_req_if;
    logic               valid;
    logic               ready;
    logic               cmd;
    logic signed [31:0] in_x;
    logic signed [31:0] in_y;
    logic signed [31:0] in_z;

    modport source (output valid, cmd, in_x, in_y, in_z, input ready);
    modport sink (input valid, cmd, in_x, in_y, in_z, output ready);
endinterface
`default_nettype wire

>>> design/ppu_rsp_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Response channel
// Carries one projection result word with its status.
// ----------------------------------------------------------------------------
interface ppu_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic [1:0]         status;

    modport source (output valid, out_x, out_y, out_z, status, input ready);
    modport sink (input valid, out_x, out_y, out_z, status, output ready);
endinterface
`default_nettype wire

>>> design/ppu_cfg_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Configuration channel
// Carries one register write word: register index and write data.
// ----------------------------------------------------------------------------
interface ppu_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> design/ppu_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Projection front end
// Accepts request words, flags zero depth and forms the first operands.
// ----------------------------------------------------------------------------
module ppu_front #(
    parameter int FRAC_BITS = ppu_pkg::FRAC_BITS_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire ppu_pkg::t_cfg i_cfg,
    ppu_req_if.sink            i_req,
    output logic               o_vld,
    output ppu_pkg::t_job      o_job,
    input  wire logic          i_rdy
);
    localparam int AW = ppu_pkg::A_W;
    localparam longint ONE = 64'sd1 <<< FRAC_BITS;

    logic          r_vld;
    ppu_pkg::t_job r_job;
    ppu_pkg::t_job n_job;
    logic          take;

    assign i_req.ready = !r_vld || i_rdy;
    assign take = i_req.valid && i_req.ready;

    always_comb begin
        n_job      = '0;
        n_job.cmd  = ppu_pkg::t_cmd'(i_req.cmd);
        n_job.zero = (i_req.in_z == '0);
        n_job.z    = i_req.in_z;
        n_job.zmag = i_req.in_z[31] ? 32'(-i_req.in_z) : 32'(i_req.in_z);
        if (n_job.cmd == ppu_pkg::CMD_FWD) begin
            n_job.ax = AW'(i_req.in_x);
            n_job.ay = AW'(i_req.in_y);
        end else if (i_cfg.device_space) begin
            n_job.ax = AW'(i_req.in_x) + AW'(ONE) - (AW'(i_cfg.center_x) <<< 1);
            n_job.ay = AW'(i_req.in_y) + AW'(ONE) - (AW'(i_cfg.center_y) <<< 1);
        end else begin
            n_job.ax = AW'(i_req.in_x) - AW'(i_cfg.center_x);
            n_job.ay = AW'(i_req.in_y) - AW'(i_cfg.center_y);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_req.ready) begin
            r_vld <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_job <= n_job;
        end
    end

    assign o_vld = r_vld;
    assign o_job = r_job;
endmodule
`default_nettype wire

>>> design/ppu_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Job queue
// Short queue between the front end and the arithmetic back end.
// ----------------------------------------------------------------------------
module ppu_fifo (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_vld,
    input  wire ppu_pkg::t_job i_job,
    output logic               o_rdy,
    output logic               o_vld,
    output ppu_pkg::t_job      o_job,
    input  wire logic          i_pop
);
    localparam int DEPTH = ppu_pkg::FIFO_DEPTH;
    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    ppu_pkg::t_job r_mem [DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [CW-1:0] r_cnt;
    logic          push;
    logic          pop;

    assign o_rdy = (r_cnt != CW'(DEPTH));
    assign o_vld = (r_cnt != '0);
    assign push  = i_vld && o_rdy;
    assign pop   = i_pop && o_vld;
    assign o_job = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= r_wr + PW'(1);
            end
            if (pop) begin
                r_rd <= r_rd + PW'(1);
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (pop && !push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_job;
        end
    end

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(DEPTH))
        else $error("Queue fill count exceeds its depth.");
    a_cnt_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push && !pop |=> r_cnt == $past(r_cnt) + CW'(1))
        else $error("Queue fill count missed a push.");
`endif
endmodule
`default_nettype wire

>>> design/ppu_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Reciprocal divider
// Pipelined restoring divider, one quotient bit per stage, forming
// inv_fov / z in fixed point.
// ----------------------------------------------------------------------------
module ppu_div #(
    parameter int FRAC_BITS = ppu_pkg::FRAC_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_en,
    input  wire logic [ppu_pkg::RATIO_W-1:0]   i_inv_fov,
    input  wire logic                          i_vld,
    input  wire ppu_pkg::t_job                 i_job,
    output logic                               o_vld,
    output ppu_pkg::t_job                      o_job
);
    localparam int QB = ppu_pkg::RATIO_W + FRAC_BITS;
    localparam int BW = ppu_pkg::B_W;

    logic [31:0]   r_rem [QB];
    logic [QB-1:0] r_q   [QB];
    ppu_pkg::t_job r_job [QB];
    logic          r_vld [QB];

    ppu_pkg::t_job         r_o_job;
    logic                  r_o_vld;
    logic signed [BW-1:0]  q_ext;
    ppu_pkg::t_job         n_o_job;

    for (genvar k = 0; k < QB; k++) begin : g_stage
        localparam int BI = QB - 1 - k;
        logic [31:0]   rem_in;
        logic [QB-1:0] q_in;
        ppu_pkg::t_job job_in;
        logic          vld_in;
        logic          nbit;
        logic [32:0]   sh;
        logic [32:0]   diff;
        logic          ge;
        logic [QB-1:0] n_q;

        if (k == 0) begin : g_first
            assign rem_in = '0;
            assign q_in   = '0;
            assign job_in = i_job;
            assign vld_in = i_vld;
        end else begin : g_next
            assign rem_in = r_rem[k-1];
            assign q_in   = r_q[k-1];
            assign job_in = r_job[k-1];
            assign vld_in = r_vld[k-1];
        end

        if (BI >= FRAC_BITS) begin : g_bit
            assign nbit = i_inv_fov[BI-FRAC_BITS];
        end else begin : g_low
            assign nbit = 1'b0;
        end

        assign sh   = {rem_in, nbit};
        assign diff = sh - {1'b0, job_in.zmag};
        assign ge   = (sh >= {1'b0, job_in.zmag});

        always_comb begin
            n_q     = q_in;
            n_q[BI] = ge;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= ge ? diff[31:0] : sh[31:0];
                r_q[k]   <= n_q;
                r_job[k] <= job_in;
            end
        end
    end

    assign q_ext = BW'(r_q[QB-1]);

    always_comb begin
        n_o_job    = r_job[QB-1];
        n_o_job.iz = r_job[QB-1].z[31] ? -q_ext : q_ext;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (i_en) begin
            r_o_vld <= r_vld[QB-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_o_job <= n_o_job;
        end
    end

    assign o_vld = r_o_vld;
    assign o_job = r_o_job;
endmodule
`default_nettype wire

>>> design/ppu_mul.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Fixed-point multiplier pair
// Two lanes of sign-magnitude fixed-point multiply with rounding and
// clamping, built from 32-bit partial products over five stages.
// ----------------------------------------------------------------------------
module ppu_mul #(
    parameter int FRAC_BITS = ppu_pkg::FRAC_BITS_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_en,
    input  wire logic                         i_vld,
    input  wire ppu_pkg::t_job                i_job,
    input  wire logic signed [ppu_pkg::A_W-1:0] i_a [2],
    input  wire logic signed [ppu_pkg::B_W-1:0] i_b [2],
    output logic                              o_vld,
    output ppu_pkg::t_job                     o_job,
    output logic signed [ppu_pkg::A_W-1:0]    o_m [2]
);
    localparam int AW  = ppu_pkg::A_W;
    localparam int BW  = ppu_pkg::B_W;
    localparam int MAW = ppu_pkg::MA_W;
    localparam int MBW = ppu_pkg::MB_W;
    localparam int LAT = 5;
    localparam int PW  = MAW + MBW + 1;
    localparam int LOW = 96;
    localparam int HIW = 85;

    logic          r_vld [LAT];
    ppu_pkg::t_job r_job [LAT];

    logic [MAW-1:0]       r_ma  [2];
    logic [MBW-1:0]       r_mb  [2];
    logic [63:0]          r_pll [2];
    logic [60:0]          r_phl [2];
    logic [54:0]          r_plh [2];
    logic [51:0]          r_phh [2];
    logic [LOW-1:0]       r_lo  [2];
    logic [HIW-1:0]       r_hi  [2];
    logic [PW-1:0]        r_p   [2];
    logic signed [AW-1:0] r_m   [2];
    logic [3:0]           r_neg [2];

    logic [AW-1:0]  abs_a [2];
    logic [BW-1:0]  abs_b [2];
    logic [64:0]    rnd   [2];
    logic           big   [2];
    logic [MAW-1:0] mag   [2];

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            abs_a[l] = i_a[l][AW-1] ? AW'(-i_a[l]) : AW'(i_a[l]);
            abs_b[l] = i_b[l][BW-1] ? BW'(-i_b[l]) : BW'(i_b[l]);
            rnd[l]   = 65'(r_p[l][63:FRAC_BITS]) + 65'(r_p[l][FRAC_BITS-1]);
            big[l]   = (|r_p[l][PW-1:64]) || (rnd[l] > 65'(ppu_pkg::BIG_MAG));
            mag[l]   = big[l] ? ppu_pkg::BIG_MAG : rnd[l][MAW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int l = 0; l < 2; l++) begin
                r_neg[l] <= {r_neg[l][2:0], i_a[l][AW-1] ^ i_b[l][BW-1]};
                r_ma[l]  <= abs_a[l][MAW-1:0];
                r_mb[l]  <= abs_b[l][MBW-1:0];
                r_pll[l] <= r_ma[l][31:0] * r_mb[l][31:0];
                r_phl[l] <= r_ma[l][MAW-1:32] * r_mb[l][31:0];
                r_plh[l] <= r_ma[l][31:0] * r_mb[l][MBW-1:32];
                r_phh[l] <= r_ma[l][MAW-1:32] * r_mb[l][MBW-1:32];
                r_lo[l]  <= LOW'(r_pll[l]) + LOW'({r_phl[l], 32'h0});
                r_hi[l]  <= HIW'(r_plh[l]) + HIW'({r_phh[l], 32'h0});
                r_p[l]   <= PW'(r_lo[l]) + PW'({r_hi[l], 32'h0});
                r_m[l]   <= r_neg[l][3] ? -AW'(mag[l]) : AW'(mag[l]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < LAT; s++) begin
                r_vld[s] <= 1'b0;
            end
        end else if (i_en) begin
            r_vld[0] <= i_vld;
            for (int s = 1; s < LAT; s++) begin
                r_vld[s] <= r_vld[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_job[0] <= i_job;
            for (int s = 1; s < LAT; s++) begin
                r_job[s] <= r_job[s-1];
            end
        end
    end

    assign o_vld = r_vld[LAT-1];
    assign o_job = r_job[LAT-1];
    assign o_m   = r_m;
endmodule
`default_nettype wire

>>> design/ppu_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Projection back end
// Reciprocal, three multiply rounds, centering, device-space mapping,
// saturation and the output register.
// ----------------------------------------------------------------------------
module ppu_back #(
    parameter int FRAC_BITS = ppu_pkg::FRAC_BITS_DEF,
    parameter int WORD_BITS = ppu_pkg::WORD_BITS_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire ppu_pkg::t_cfg i_cfg,
    input  wire logic          i_vld,
    input  wire ppu_pkg::t_job i_job,
    output logic               o_pop,
    output logic               o_vld,
    output ppu_pkg::t_result   o_res,
    input  wire logic          i_rdy
);
    localparam int AW = ppu_pkg::A_W;
    localparam int BW = ppu_pkg::B_W;
    localparam int SAT_BITS = (WORD_BITS < 32) ? WORD_BITS : 32;
    localparam longint ONE = 64'sd1 <<< FRAC_BITS;
    localparam longint BIG = 64'sd1 <<< 60;
    localparam longint HI = (64'sd1 <<< (SAT_BITS - 1)) - 64'sd1;
    localparam longint LO = -HI - 64'sd1;
    localparam logic signed [BW-1:0] ONE_B = BW'(ONE);

    logic en;

    logic                 d_vld;
    ppu_pkg::t_job        d_job;
    logic                 m1_vld;
    ppu_pkg::t_job        m1_job;
    logic signed [AW-1:0] m1_m [2];
    logic                 m2_vld;
    ppu_pkg::t_job        m2_job;
    logic signed [AW-1:0] m2_m [2];
    logic                 m3_vld;
    ppu_pkg::t_job        m3_job;
    logic signed [AW-1:0] m3_m [2];

    logic signed [AW-1:0] a1 [2];
    logic signed [BW-1:0] b1 [2];
    logic signed [BW-1:0] b2 [2];
    logic signed [BW-1:0] b3 [2];

    logic                 r_f_vld;
    ppu_pkg::t_job        r_f_job;
    logic signed [63:0]   r_f_v [2];
    logic signed [63:0]   n_f_v [2];

    logic                 r_out_vld;
    ppu_pkg::t_result     r_out;
    ppu_pkg::t_result     n_out;

    assign en    = !r_out_vld || i_rdy;
    assign o_pop = en;

    ppu_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_inv_fov (i_cfg.inv_fov),
        .i_vld     (i_vld),
        .i_job     (i_job),
        .o_vld     (d_vld),
        .o_job     (d_job)
    );

    always_comb begin
        a1[0] = d_job.ax;
        a1[1] = d_job.ay;
        if (d_job.cmd == ppu_pkg::CMD_FWD) begin
            b1[0] = BW'(i_cfg.inv_aspect);
            b1[1] = d_job.iz;
        end else begin
            b1[0] = BW'(d_job.z);
            b1[1] = BW'(d_job.z);
        end
        if (m1_job.cmd == ppu_pkg::CMD_FWD) begin
            b2[0] = m1_job.iz;
            b2[1] = ONE_B;
        end else begin
            b2[0] = BW'(i_cfg.fov);
            b2[1] = BW'(i_cfg.fov);
        end
        b3[0] = (m2_job.cmd == ppu_pkg::CMD_FWD) ? ONE_B : BW'(i_cfg.aspect);
        b3[1] = ONE_B;
    end

    ppu_mul #(.FRAC_BITS(FRAC_BITS)) u_mul1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (d_vld),
        .i_job   (d_job),
        .i_a     (a1),
        .i_b     (b1),
        .o_vld   (m1_vld),
        .o_job   (m1_job),
        .o_m     (m1_m)
    );

    ppu_mul #(.FRAC_BITS(FRAC_BITS)) u_mul2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (m1_vld),
        .i_job   (m1_job),
        .i_a     (m1_m),
        .i_b     (b2),
        .o_vld   (m2_vld),
        .o_job   (m2_job),
        .o_m     (m2_m)
    );

    ppu_mul #(.FRAC_BITS(FRAC_BITS)) u_mul3 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (m2_vld),
        .i_job   (m2_job),
        .i_a     (m2_m),
        .i_b     (b3),
        .o_vld   (m3_vld),
        .o_job   (m3_job),
        .o_m     (m3_m)
    );

    // Forward results are shifted by the screen center and clamped.
    always_comb begin
        logic signed [63:0] s [2];
        s[0] = 64'(m3_m[0]) + 64'(i_cfg.center_x);
        s[1] = 64'(m3_m[1]) + 64'(i_cfg.center_y);
        for (int l = 0; l < 2; l++) begin
            if (m3_job.cmd == ppu_pkg::CMD_FWD) begin
                if (s[l] > BIG) begin
                    n_f_v[l] = BIG;
                end else if (s[l] < -BIG) begin
                    n_f_v[l] = -BIG;
                end else begin
                    n_f_v[l] = s[l];
                end
            end else begin
                n_f_v[l] = 64'(m3_m[l]);
            end
        end
    end

    always_comb begin
        logic signed [63:0] u [2];
        logic signed [63:0] q [2];
        logic               flag;
        flag = 1'b0;
        for (int l = 0; l < 2; l++) begin
            if (!i_cfg.device_space) begin
                u[l] = r_f_v[l];
            end else if (r_f_job.cmd == ppu_pkg::CMD_FWD) begin
                u[l] = (r_f_v[l] <<< 1) - ONE;
            end else if (r_f_v[l] < 0) begin
                u[l] = r_f_v[l] >>> 1;
            end else begin
                u[l] = (r_f_v[l] + 64'sd1) >>> 1;
            end
            if (u[l] > HI) begin
                q[l] = HI;
                flag = 1'b1;
            end else if (u[l] < LO) begin
                q[l] = LO;
                flag = 1'b1;
            end else begin
                q[l] = u[l];
            end
        end
        n_out.out_x = 32'(q[0]);
        n_out.out_y = 32'(q[1]);
        n_out.out_z = (r_f_job.cmd == ppu_pkg::CMD_INV) ? r_f_job.z : '0;
        n_out.status = flag ? ppu_pkg::ST_SAT : ppu_pkg::ST_OK;
        if (r_f_job.cmd == ppu_pkg::CMD_FWD && r_f_job.zero) begin
            n_out.out_x  = '0;
            n_out.out_y  = '0;
            n_out.out_z  = '0;
            n_out.status = ppu_pkg::ST_ZERO;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_vld   <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_f_vld   <= m3_vld;
            r_out_vld <= r_f_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_f_job <= m3_job;
            r_f_v   <= n_f_v;
            r_out   <= n_out;
        end
    end

    assign o_vld = r_out_vld;
    assign o_res = r_out;

`ifndef SYNTHESIS
    a_zero_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && r_out.status == ppu_pkg::ST_ZERO
        |-> r_out.out_x == '0 && r_out.out_y == '0 && r_out.out_z == '0)
        else $error("Zero-depth word carries nonzero coordinates.");
    a_sat_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && r_out.status == ppu_pkg::ST_SAT
        |-> r_out.out_x == 32'(HI) || r_out.out_x == 32'(LO)
            || r_out.out_y == 32'(HI) || r_out.out_y == 32'(LO))
        else $error("Saturated word has no coordinate at a bound.");
`endif
endmodule
`default_nettype wire

>>> design/perspective_projection_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Perspective projection unit
// Pinhole camera projection and its inverse in signed fixed point, with a
// decoupled front end, job queue and pipelined arithmetic back end.
// ----------------------------------------------------------------------------
// The unit takes one request word per clock and returns one result word per
// request, in order, at a sustained rate of one word per cycle while the
// response side does not hold the flow. From acceptance, a request passes the
// front-end register, the queue, the reciprocal divider with one quotient bit
// per stage, three five-stage multiply rounds and the finishing stages. A
// four-word queue between front end and back end absorbs stalls on the
// response side. Configuration words are accepted every cycle and must be
// written while no request is in flight.
module perspective_projection_unit #(
    parameter int FRAC_BITS = ppu_pkg::FRAC_BITS_DEF,
    parameter int WORD_BITS = ppu_pkg::WORD_BITS_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    ppu_req_if.sink   i_req,
    ppu_rsp_if.source o_rsp,
    ppu_cfg_if.sink   i_cfg
);
    localparam int RW = ppu_pkg::RATIO_W;
    localparam logic [RW-1:0] ONE_R = RW'(64'd1 << FRAC_BITS);
    localparam logic signed [31:0] HALF = 32'(64'd1 << (FRAC_BITS - 1));

    ppu_pkg::t_cfg    r_cfg;
    ppu_pkg::t_cfg    n_cfg;
    logic             f_vld;
    ppu_pkg::t_job    f_job;
    logic             q_rdy;
    logic             q_vld;
    ppu_pkg::t_job    q_job;
    logic             pop;
    ppu_pkg::t_result res;

    assign i_cfg.ready = 1'b1;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg.valid) begin
            case (ppu_pkg::t_reg'(i_cfg.index))
                ppu_pkg::REG_INV_FOV:      n_cfg.inv_fov = i_cfg.data[RW-1:0];
                ppu_pkg::REG_FOV:          n_cfg.fov = i_cfg.data[RW-1:0];
                ppu_pkg::REG_ASPECT:       n_cfg.aspect = i_cfg.data[RW-1:0];
                ppu_pkg::REG_INV_ASPECT:   n_cfg.inv_aspect = i_cfg.data[RW-1:0];
                ppu_pkg::REG_CENTER_X:     n_cfg.center_x = i_cfg.data;
                ppu_pkg::REG_CENTER_Y:     n_cfg.center_y = i_cfg.data;
                ppu_pkg::REG_DEVICE_SPACE: n_cfg.device_space = i_cfg.data[0];
                default: n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.inv_fov      <= ONE_R;
            r_cfg.fov          <= ONE_R;
            r_cfg.aspect       <= ONE_R;
            r_cfg.inv_aspect   <= ONE_R;
            r_cfg.center_x     <= HALF;
            r_cfg.center_y     <= HALF;
            r_cfg.device_space <= 1'b0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    ppu_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_req   (i_req),
        .o_vld   (f_vld),
        .o_job   (f_job),
        .i_rdy   (q_rdy)
    );

    ppu_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (f_vld),
        .i_job   (f_job),
        .o_rdy   (q_rdy),
        .o_vld   (q_vld),
        .o_job   (q_job),
        .i_pop   (pop)
    );

    ppu_back #(.FRAC_BITS(FRAC_BITS), .WORD_BITS(WORD_BITS)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_vld   (q_vld),
        .i_job   (q_job),
        .o_pop   (pop),
        .o_vld   (o_rsp.valid),
        .o_res   (res),
        .i_rdy   (o_rsp.ready)
    );

    assign o_rsp.out_x  = res.out_x;
    assign o_rsp.out_y  = res.out_y;
    assign o_rsp.out_z  = res.out_z;
    assign o_rsp.status = res.status;
endmodule
`default_nettype wire

>>> dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Perspective projection unit testbench
// Drives forward and inverse requests under several register settings,
// checks every result word field by field against a fixed-point prediction
// or directed value, with random idling on both channels and back-pressure.
// ----------------------------------------------------------------------------
module tb;

    localparam logic [ppu_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
    localparam longint FX_ONE = 64'sd65536;
    localparam longint MAG_CAP = 64'sd1 <<< 60;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES = 90;
    localparam int ITEMS_PER_PHASE = 245;

    typedef struct {
        ppu_pkg::t_cmd    cmd;
        logic [31:0]      x;
        logic [31:0]      y;
        logic [31:0]      z;
        bit               typed;
        ppu_pkg::t_result res;
    } t_row;

    logic i_clk;
    logic i_rst_n;

    ppu_req_if req_if ();
    ppu_rsp_if rsp_if ();
    ppu_cfg_if cfg_if ();

    perspective_projection_unit DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if),
        .i_cfg   (cfg_if)
    );

    ppu_pkg::t_cfg    cam;
    ppu_pkg::t_result pending_q[$];
    int      errors;
    int      n_fwd, n_inv, n_zero, n_words, n_cfg;
    bit      idle_on;
    int      hold_cycles;
    int      stall_cnt;

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic longint mul_round(longint a, longint b);
        bit           neg;
        logic [63:0]  ma;
        logic [63:0]  mb;
        logic [63:0]  m;
        logic [127:0] p;
        neg = (a < 0) != (b < 0);
        ma = (a < 0) ? -a : a;
        mb = (b < 0) ? -b : b;
        p = {64'd0, ma} * {64'd0, mb};
        if (p[127:64] != 0) begin
            m = MAG_CAP;
        end else begin
            m = (p[63:0] >> 16) + p[15];
            if (m > MAG_CAP) m = MAG_CAP;
        end
        return neg ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint clamp_cap(longint v);
        if (v > MAG_CAP) return MAG_CAP;
        if (v < -MAG_CAP) return -MAG_CAP;
        return v;
    endfunction

    function automatic longint halve_away(longint v);
        if (v >= 0) return (v + 1) / 2;
        return -((-v + 1) / 2);
    endfunction

    function automatic logic [31:0] sat_word(longint v, ref bit flag);
        if (v > 64'sd2147483647) begin
            flag = 1'b1;
            return 32'h7fff_ffff;
        end
        if (v < -64'sd2147483648) begin
            flag = 1'b1;
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

    function automatic ppu_pkg::t_result project(ppu_pkg::t_cmd cmd, logic [31:0] xw,
                                                 logic [31:0] yw, logic [31:0] zw);
        ppu_pkg::t_result r;
        longint  x, y, z, iz, rx, ry, dx, dy, cx, cy;
        bit      flag;
        x = longint'($signed(xw));
        y = longint'($signed(yw));
        z = longint'($signed(zw));
        cx = longint'(cam.center_x);
        cy = longint'(cam.center_y);
        flag = 1'b0;
        r.out_z = '0;
        if (cmd == ppu_pkg::CMD_FWD) begin
            if (z == 0) begin
                r.out_x = '0;
                r.out_y = '0;
                r.status = ppu_pkg::ST_ZERO;
                return r;
            end
            iz = (longint'(cam.inv_fov) * FX_ONE) / z;
            rx = clamp_cap(mul_round(mul_round(x, longint'(cam.inv_aspect)), iz) + cx);
            ry = clamp_cap(mul_round(y, iz) + cy);
            if (cam.device_space) begin
                rx = rx * 2 - FX_ONE;
                ry = ry * 2 - FX_ONE;
            end
        end else begin
            if (cam.device_space) begin
                dx = x + FX_ONE - 2 * cx;
                dy = y + FX_ONE - 2 * cy;
            end else begin
                dx = x - cx;
                dy = y - cy;
            end
            rx = mul_round(mul_round(mul_round(dx, z), longint'(cam.fov)),
                           longint'(cam.aspect));
            ry = mul_round(mul_round(dy, z), longint'(cam.fov));
            if (cam.device_space) begin
                rx = halve_away(rx);
                ry = halve_away(ry);
            end
            r.out_z = zw;
        end
        r.out_x = sat_word(rx, flag);
        r.out_y = sat_word(ry, flag);
        r.status = flag ? ppu_pkg::ST_SAT : ppu_pkg::ST_OK;
        return r;
    endfunction

    task automatic report(string field, logic [31:0] got, logic [31:0] want);
        errors++;
        $display("%0t: mismatch on %s: got %h, expected %h", $time, field, got, want);
    endtask

    always @(posedge i_clk) begin
        ppu_pkg::t_result want;
        if (rsp_if.valid && rsp_if.ready) begin
            n_words++;
            if (pending_q.size() == 0) begin
                report("unexpected word", rsp_if.out_x, 32'h0);
            end else begin
                want = pending_q.pop_front();
                if (rsp_if.out_x !== want.out_x) report("out_x", rsp_if.out_x, want.out_x);
                if (rsp_if.out_y !== want.out_y) report("out_y", rsp_if.out_y, want.out_y);
                if (rsp_if.out_z !== want.out_z) report("out_z", rsp_if.out_z, want.out_z);
                if (rsp_if.status !== want.status) begin
                    report("status", 32'(rsp_if.status), 32'(want.status));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
            (cfg_if.valid && cfg_if.ready) || !i_rst_n) begin
            stall_cnt <= 0;
        end else if (stall_cnt >= WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", stall_cnt);
            $display("TEST FAILED");
            $finish;
        end else begin
            stall_cnt <= stall_cnt + 1;
        end
    end

    initial begin
        rsp_if.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_cycles > 0) begin
                rsp_if.ready <= 1'b0;
                repeat (hold_cycles) @(posedge i_clk);
                hold_cycles = 0;
            end else if (idle_on && $urandom_range(0, 9) == 0) begin
                rsp_if.ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge i_clk);
            end else begin
                rsp_if.ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    task automatic send(ppu_pkg::t_cmd cmd, logic [31:0] x, logic [31:0] y,
                        logic [31:0] z, bit typed, ppu_pkg::t_result res);
        if (idle_on && $urandom_range(0, 9) == 0) begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.cmd <= cmd;
        req_if.in_x <= x;
        req_if.in_y <= y;
        req_if.in_z <= z;
        do @(posedge i_clk); while (!req_if.ready);
        pending_q.push_back(typed ? res : project(cmd, x, y, z));
        if (cmd == ppu_pkg::CMD_FWD) n_fwd++;
        else n_inv++;
        if (cmd == ppu_pkg::CMD_FWD && z == 0) n_zero++;
    endtask

    task automatic drain(bit settle);
        req_if.valid <= 1'b0;
        cfg_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_q.size() != 0) @(posedge i_clk);
        if (settle) repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [ppu_pkg::CFG_IDX_W-1:0] idx, logic [31:0] data);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data <= data;
        do @(posedge i_clk); while (!cfg_if.ready);
        n_cfg++;
        case (idx)
            ppu_pkg::REG_INV_FOV:      cam.inv_fov = data[30:0];
            ppu_pkg::REG_FOV:          cam.fov = data[30:0];
            ppu_pkg::REG_ASPECT:       cam.aspect = data[30:0];
            ppu_pkg::REG_INV_ASPECT:   cam.inv_aspect = data[30:0];
            ppu_pkg::REG_CENTER_X:     cam.center_x = data;
            ppu_pkg::REG_CENTER_Y:     cam.center_y = data;
            ppu_pkg::REG_DEVICE_SPACE: cam.device_space = data[0];
            default: ;
        endcase
    endtask

    function automatic logic [31:0] rand_ratio();
        if ($urandom_range(0, 1)) return $urandom_range(16384, 262144);
        return $urandom >> $urandom_range(1, 31);
    endfunction

    function automatic logic [31:0] rand_fx();
        logic signed [31:0] v;
        v = $urandom;
        return v >>> $urandom_range(0, 31);
    endfunction

    task automatic program_camera(int kind);
        logic [31:0] r[4];
        logic [31:0] cx, cy;
        logic [31:0] dev;
        case (kind)
            1: begin
                r = '{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff};
                cx = 32'h7fff_ffff;
                cy = 32'h8000_0000;
                dev = 32'd1;
            end
            2: begin
                r = '{32'd1, 32'd1, 32'd1, 32'd1};
                cx = 32'h8000_0000;
                cy = 32'h7fff_ffff;
                dev = 32'd0;
            end
            3: begin
                r = '{32'd0, 32'd0, 32'hffff_ffff, 32'd0};
                cx = 32'd0;
                cy = 32'd0;
                dev = 32'hffff_fffe;
            end
            default: begin
                foreach (r[i]) r[i] = rand_ratio();
                r[$urandom_range(0, 3)] = 32'h0001_0000;
                cx = $urandom_range(0, 1) ? rand_fx() : $urandom_range(0, 65536);
                cy = $urandom_range(0, 1) ? rand_fx() : $urandom_range(0, 65536);
                dev = $urandom;
            end
        endcase
        write_reg(ppu_pkg::REG_INV_FOV, r[0]);
        write_reg(ppu_pkg::REG_FOV, r[1]);
        write_reg(ppu_pkg::REG_ASPECT, r[2]);
        write_reg(ppu_pkg::REG_INV_ASPECT, r[3]);
        write_reg(ppu_pkg::REG_CENTER_X, cx);
        write_reg(ppu_pkg::REG_CENTER_Y, cy);
        write_reg(ppu_pkg::REG_DEVICE_SPACE, dev);
        write_reg(REG_UNUSED, $urandom);
        cfg_if.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic random_items(int count);
        ppu_pkg::t_cmd    c;
        logic [31:0]      z;
        ppu_pkg::t_result none;
        none = '0;
        for (int i = 0; i < count; i++) begin
            c = $urandom_range(0, 1) ? ppu_pkg::CMD_INV : ppu_pkg::CMD_FWD;
            case ($urandom_range(0, 9))
                0: z = 32'd0;
                1: z = $urandom;
                2: z = $urandom_range(1, 8) << 16;
                default: z = rand_fx();
            endcase
            send(c, rand_fx(), rand_fx(), z, 1'b0, none);
        end
    endtask

    t_row directed[$];

    initial begin
        errors = 0;
        hold_cycles = 0;
        idle_on = 1'b1;
        i_rst_n <= 1'b0;
        req_if.valid <= 1'b0;
        req_if.cmd <= 1'b0;
        req_if.in_x <= '0;
        req_if.in_y <= '0;
        req_if.in_z <= '0;
        cfg_if.valid <= 1'b0;
        cfg_if.index <= '0;
        cfg_if.data <= '0;
        cam.inv_fov = 31'h1_0000;
        cam.fov = 31'h1_0000;
        cam.aspect = 31'h1_0000;
        cam.inv_aspect = 31'h1_0000;
        cam.center_x = 32'h8000;
        cam.center_y = 32'h8000;
        cam.device_space = 1'b0;

        directed = '{
            '{ppu_pkg::CMD_FWD, 32'h0,         32'h0,         32'h1_0000,    1,
              '{32'h8000, 32'h8000, 0, ppu_pkg::ST_OK}},
            '{ppu_pkg::CMD_FWD, 32'h1234_5678, 32'h8000_0000, 32'h0,         1,
              '{0, 0, 0, ppu_pkg::ST_ZERO}},
            '{ppu_pkg::CMD_FWD, 32'h0,         32'h0,         32'h1,         1,
              '{32'h8000, 32'h8000, 0, ppu_pkg::ST_OK}},
            '{ppu_pkg::CMD_FWD, 32'h7fff_ffff, 32'h8000_0000, 32'h1,         1,
              '{32'h7fff_ffff, 32'h8000_0000, 0, ppu_pkg::ST_SAT}},
            '{ppu_pkg::CMD_INV, 32'h8000,      32'h8000,      32'h7fff_ffff, 1,
              '{0, 0, 32'h7fff_ffff, ppu_pkg::ST_OK}},
            '{ppu_pkg::CMD_INV, 32'h7fff_ffff, 32'h8000_0000, 32'h0,         1,
              '{0, 0, 0, ppu_pkg::ST_OK}},
            '{ppu_pkg::CMD_FWD, 32'h1_0000,    32'hffff_0000, 32'h2_0000,    0,
              '{0, 0, 0, ppu_pkg::ST_OK}},
            '{ppu_pkg::CMD_FWD, 32'hffff_ffff, 32'h1,         32'hffff_ffff, 0,
              '{0, 0, 0, ppu_pkg::ST_OK}},
            '{ppu_pkg::CMD_FWD, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 0,
              '{0, 0, 0, ppu_pkg::ST_OK}},
            '{ppu_pkg::CMD_FWD, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0,
              '{0, 0, 0, ppu_pkg::ST_OK}},
            '{ppu_pkg::CMD_FWD, 32'h3_0000,    32'h5_8000,    32'hfffe_0000, 0,
              '{0, 0, 0, ppu_pkg::ST_OK}},
            '{ppu_pkg::CMD_INV, 32'h1_0000,    32'h0,         32'h4_0000,    0,
              '{0, 0, 0, ppu_pkg::ST_OK}},
            '{ppu_pkg::CMD_INV, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 0,
              '{0, 0, 0, ppu_pkg::ST_OK}},
            '{ppu_pkg::CMD_INV, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0,
              '{0, 0, 0, ppu_pkg::ST_OK}},
            '{ppu_pkg::CMD_INV, 32'hffff_ffff, 32'h1,         32'h8000_0000, 0,
              '{0, 0, 0, ppu_pkg::ST_OK}},
            '{ppu_pkg::CMD_INV, 32'h0,         32'hffff_8000, 32'hffff_0001, 0,
              '{0, 0, 0, ppu_pkg::ST_OK}}
        };

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[i]) begin
            send(directed[i].cmd, directed[i].x, directed[i].y, directed[i].z,
                 directed[i].typed, directed[i].res);
        end
        random_items(ITEMS_PER_PHASE / 2);
        drain(1'b1);

        for (int phase = 1; phase <= 7; phase++) begin
            program_camera(phase);
            if (phase == 7) idle_on = 1'b0;
            if (phase == 2) hold_cycles = 400;
            if (phase == 3) begin
                random_items(ITEMS_PER_PHASE / 2);
                drain(1'b0);
                random_items(ITEMS_PER_PHASE / 2);
            end else begin
                random_items(ITEMS_PER_PHASE);
            end
            drain(1'b1);
        end

        $display("Covered %0d forward and %0d inverse requests (%0d with zero depth) over",
                 n_fwd, n_inv, n_zero);
        $display("8 camera settings with %0d register writes; %0d result words checked.",
                 n_cfg, n_words);
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule

>>> files.f
design/ppu_pkg.sv
design/ppu_req_if.sv
design/ppu_rsp_if.sv
design/ppu_cfg_if.sv
design/ppu_front.sv
design/ppu_fifo.sv
design/ppu_div.sv
design/ppu_mul.sv
design/ppu_back.sv
design/perspective_projection_unit.sv
dv/tb.sv
